### src/ring_server_allocator_core_macros.svh
// ----------------------------------------------------------------------------
// Ring server allocator assertion macros
// Shared property forms for the allocator's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef RING_SERVER_ALLOCATOR_CORE_MACROS_SVH
`define RING_SERVER_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define RSA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define RSA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/rsa_pkg.sv
// ----------------------------------------------------------------------------
// Ring server allocator package
// Widths, defaults, controller states and cell interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package rsa_pkg;

  localparam int MAX_SERVERS_DEF = 64;
  localparam int CFG_W           = 7;
  localparam int TIME_W          = 32;
  localparam int COUNT_W         = 16;
  localparam int OUT_IDX_W       = 6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_PICK
  } state_t;

  // Strobes from the controller to every cell.
  typedef struct packed {
    logic cmp_en;
    logic upd_en;
  } cell_ctl_t;

  // Priority carries handed down the row: hi covers the preferred
  // segment, lo covers every free server.
  typedef struct packed {
    logic hi;
    logic lo;
  } chain_t;

endpackage

`default_nettype wire

### src/ring_server_allocator_core.sv
// ----------------------------------------------------------------------------
// Ring server allocator core
// Rotating-priority allocator over a row of server cells.
// ----------------------------------------------------------------------------
//   channel  direction  handshake            payload
//   in       input      in_valid/in_ready    arrival_time, service_time
//   out      output     out_valid/out_ready  granted, server_index, served_count
//   cfg      input      cfg_valid/cfg_ready  cfg_data (num_servers)
//
// A request passes a compare state, where every cell compares its release time,
// then a pick state, where the carry chain through the cells picks and updates
// the winner. The next request is taken in the pick state; the result is
// registered from it. Reset clears all servers at once, no clearing pass.
// A result not yet taken holds the pick stage and blocks the next request.
// ----------------------------------------------------------------------------
`default_nettype none

module ring_server_allocator_core #(
  parameter int MAX_SERVERS = rsa_pkg::MAX_SERVERS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output      logic                             in_ready,
  input  wire logic [rsa_pkg::TIME_W-1:0]       arrival_time,
  input  wire logic [rsa_pkg::TIME_W-1:0]       service_time,
  output      logic                             out_valid,
  input  wire logic                             out_ready,
  output      logic                             granted,
  output      logic [rsa_pkg::OUT_IDX_W-1:0]    server_index,
  output      logic [rsa_pkg::COUNT_W-1:0]      served_count,
  input  wire logic                             cfg_valid,
  output      logic                             cfg_ready,
  input  wire logic [rsa_pkg::CFG_W-1:0]        cfg_data
);
  import rsa_pkg::*;
  `include "ring_server_allocator_core_macros.svh"

  localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int CNT_W = $clog2(MAX_SERVERS + 1);
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam logic [CMP_W-1:0] MAX_N = CMP_W'(MAX_SERVERS);

  state_t state, state_next;
  cell_ctl_t ctl;
  logic out_free;

  logic [CFG_W-1:0]  num_servers;
  logic [IDX_W-1:0]  request_seq;
  logic [IDX_W-1:0]  pref;
  logic [IDX_W-1:0]  pref_c;
  logic [CMP_W-1:0]  n_act;
  logic [CMP_W-1:0]  ns_ext;
  logic [CMP_W-1:0]  seq_inc;
  logic [TIME_W-1:0] arrival;
  logic [TIME_W-1:0] service;
  logic [TIME_W-1:0] rel_new;
  logic [TIME_W:0]   sum;

  chain_t             chain [MAX_SERVERS+1];
  logic [IDX_W-1:0]   idx_g [MAX_SERVERS+1];
  logic [COUNT_W-1:0] cnt_g [MAX_SERVERS+1];
  logic [MAX_SERVERS-1:0] take_vec;
  logic hi_any;
  logic found;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;

  // Active count: zero acts as one, above the ring size clamps to it.
  always_comb begin
    ns_ext = CMP_W'(num_servers);
    if (ns_ext == '0) begin
      n_act = CMP_W'(1);
    end else if (ns_ext > MAX_N) begin
      n_act = MAX_N;
    end else begin
      n_act = ns_ext;
    end
    pref_c  = (CMP_W'(request_seq) < n_act) ? request_seq : '0;
    seq_inc = CMP_W'(pref) + CMP_W'(1);
    sum     = {1'b0, arrival} + {1'b0, service};
  end

  // Controller.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_CMP;
        end
      end
      ST_CMP: begin
        state_next = ST_PICK;
      end
      ST_PICK: begin
        if (out_free) begin
          state_next = in_valid ? ST_CMP : ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    ctl.cmp_en = 1'b0;
    ctl.upd_en = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_CMP: begin
        ctl.cmp_en = 1'b1;
      end
      ST_PICK: begin
        in_ready   = out_free;
        ctl.upd_en = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Request and configuration registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      arrival <= arrival_time;
      service <= service_time;
    end
    if (ctl.cmp_en) begin
      pref    <= pref_c;
      rel_new <= sum[TIME_W] ? '1 : sum[TIME_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_servers <= CFG_W'(64);
      request_seq <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        num_servers <= cfg_data;
      end
      // Advance the sequence on every request, granted or not.
      if (ctl.upd_en) begin
        request_seq <= (seq_inc >= n_act) ? '0 : IDX_W'(seq_inc);
      end
    end
  end

  // Row of server cells.
  assign chain[0] = '0;
  assign idx_g[0] = '0;
  assign cnt_g[0] = '0;
  assign hi_any   = chain[MAX_SERVERS].hi;
  assign found    = chain[MAX_SERVERS].lo;

  // Cells sample the preferred index in the compare cycle, before pref loads.
  for (genvar g = 0; g < MAX_SERVERS; g++) begin : g_cell
    rsa_cell #(
      .MAX_SERVERS (MAX_SERVERS),
      .IDX         (g)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .arrival   (arrival),
      .rel_new   (rel_new),
      .pref      (pref_c),
      .n_act     (n_act),
      .chain_in  (chain[g]),
      .chain_out (chain[g+1]),
      .hi_any    (hi_any),
      .idx_in    (idx_g[g]),
      .idx_out   (idx_g[g+1]),
      .cnt_in    (cnt_g[g]),
      .cnt_out   (cnt_g[g+1]),
      .take      (take_vec[g])
    );
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.upd_en) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.upd_en) begin
      granted      <= found;
      server_index <= OUT_IDX_W'(idx_g[MAX_SERVERS]);
      served_count <= cnt_g[MAX_SERVERS];
    end
  end

  `RSA_ASSERT_IMP(a_one_winner, 1'b1, $onehot0(take_vec),
                  "more than one server picked")
  `RSA_ASSERT_IMP(a_grant_counts, out_valid && granted, served_count != '0,
                  "granted result with zero served count")
  `RSA_ASSERT_IMP(a_reject_zero, out_valid && !granted,
                  server_index == '0 && served_count == '0,
                  "rejected result carries a server")
  `RSA_ASSERT_NXT(a_update_shows, ctl.upd_en, out_valid,
                  "update without a result")

endmodule

`default_nettype wire

### src/rsa_cell.sv
// ----------------------------------------------------------------------------
// Ring server allocator cell
// One server: release time, served count, free flag and priority carries.
// ----------------------------------------------------------------------------
`default_nettype none

module rsa_cell #(
  parameter int MAX_SERVERS = 64,
  parameter int IDX         = 0
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire rsa_pkg::cell_ctl_t                     ctl,
  input  wire logic [rsa_pkg::TIME_W-1:0]             arrival,
  input  wire logic [rsa_pkg::TIME_W-1:0]             rel_new,
  input  wire logic [((MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1)-1:0] pref,
  input  wire logic [(($clog2(MAX_SERVERS + 1) > rsa_pkg::CFG_W) ?
                      $clog2(MAX_SERVERS + 1) : rsa_pkg::CFG_W)-1:0] n_act,
  input  wire rsa_pkg::chain_t                        chain_in,
  output      rsa_pkg::chain_t                        chain_out,
  input  wire logic                                   hi_any,
  input  wire logic [((MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1)-1:0] idx_in,
  output      logic [((MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1)-1:0] idx_out,
  input  wire logic [rsa_pkg::COUNT_W-1:0]            cnt_in,
  output      logic [rsa_pkg::COUNT_W-1:0]            cnt_out,
  output      logic                                   take
);
  import rsa_pkg::*;

  localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int CNT_W = $clog2(MAX_SERVERS + 1);
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam logic [CMP_W-1:0] MY_N   = CMP_W'(IDX);
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic [TIME_W-1:0]  release_time;
  logic [COUNT_W-1:0] served_total;
  logic               free;
  logic               pri;
  logic [COUNT_W-1:0] cnt_next;
  logic               elig_hi;
  logic               take_hi;
  logic               take_lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      release_time <= '0;
      served_total <= '0;
    end else if (ctl.upd_en && take) begin
      release_time <= rel_new;
      served_total <= cnt_next;
    end
  end

  // Free and priority flags hold from the compare cycle through the pick.
  always_ff @(posedge clk) begin
    if (rst) begin
      free <= 1'b0;
      pri  <= 1'b0;
    end else if (ctl.cmp_en) begin
      free <= (MY_N < n_act) && (release_time <= arrival);
      pri  <= (MY_IDX >= pref);
    end
  end

  always_comb begin
    cnt_next        = (served_total == '1) ? served_total : served_total + COUNT_W'(1);
    elig_hi         = free && pri;
    take_hi         = elig_hi && !chain_in.hi;
    take_lo         = free && !chain_in.lo;
    chain_out.hi    = chain_in.hi || elig_hi;
    chain_out.lo    = chain_in.lo || free;
    take            = hi_any ? take_hi : take_lo;
    idx_out         = idx_in | (take ? MY_IDX : '0);
    cnt_out         = cnt_in | (take ? cnt_next : '0);
  end

endmodule

`default_nettype wire

### tb/sv/tb_ring_server_allocator_core.sv
// ----------------------------------------------------------------------------
// Ring server allocator core testbench
// Drives requests, server-count writes and output stalls at random, predicts
// every grant from a private copy of the ring state and compares each result
// with the oldest prediction. Covers release saturation, rejects,
// out-of-range server counts and count changes in the middle of a sequence.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic                          granted;
  logic [rsa_pkg::OUT_IDX_W-1:0] server;
  logic [rsa_pkg::COUNT_W-1:0]   count;
} alloc_grant_t;

class alloc_scoreboard;
  bit [rsa_pkg::TIME_W-1:0]  release_at [rsa_pkg::MAX_SERVERS_DEF];
  bit [rsa_pkg::COUNT_W-1:0] served [rsa_pkg::MAX_SERVERS_DEF];
  int unsigned               next_pref;
  bit [rsa_pkg::CFG_W-1:0]   servers_cfg = 7'd64;
  alloc_grant_t              expected_grants [$];
  int                        failures;

  function void report(string msg);
    if (failures < 10) $display("%s", msg);
    failures++;
  endfunction

  function void set_servers(logic [rsa_pkg::CFG_W-1:0] v);
    servers_cfg = v;
  endfunction

  // Work out the grant for one accepted request and queue it.
  function void note_request(logic [rsa_pkg::TIME_W-1:0] arrival,
                             logic [rsa_pkg::TIME_W-1:0] service);
    int unsigned              n;
    int unsigned              pref;
    int unsigned              pick;
    int unsigned              idx;
    bit                       found;
    bit [rsa_pkg::TIME_W:0]   end_at;
    alloc_grant_t             g;
    n = 32'(servers_cfg);
    if (n < 1) n = 1;
    if (n > rsa_pkg::MAX_SERVERS_DEF) n = rsa_pkg::MAX_SERVERS_DEF;
    // A sequence number left over from a larger ring restarts at zero
    pref  = (next_pref < n) ? next_pref : 0;
    found = 1'b0;
    pick  = 0;
    for (int k = 0; k < n; k++) begin
      idx = (pref + k) % n;
      if (!found && release_at[idx] <= arrival) begin
        pick  = idx;
        found = 1'b1;
      end
    end
    next_pref = (pref + 1 >= n) ? 0 : pref + 1;
    g = '0;
    if (found) begin
      end_at = {1'b0, arrival} + {1'b0, service};
      release_at[pick] = end_at[rsa_pkg::TIME_W] ? '1 : end_at[rsa_pkg::TIME_W-1:0];
      if (served[pick] != '1) served[pick]++;
      g.granted = 1'b1;
      g.server  = pick[rsa_pkg::OUT_IDX_W-1:0];
      g.count   = served[pick];
    end
    expected_grants = {expected_grants, g};
  endfunction

  function void check_grant(logic                          granted,
                            logic [rsa_pkg::OUT_IDX_W-1:0] server,
                            logic [rsa_pkg::COUNT_W-1:0]   count);
    alloc_grant_t want;
    if (expected_grants.size() == 0) begin
      report($sformatf("unexpected result: granted=%0d server=%0d count=%0d",
                       granted, server, count));
      return;
    end
    want = expected_grants.pop_front();
    if (granted !== want.granted || server !== want.server || count !== want.count)
      report($sformatf({"grant mismatch: expected granted=%0d server=%0d count=%0d,",
                        " got granted=%0d server=%0d count=%0d"},
                       want.granted, want.server, want.count, granted, server, count));
  endfunction
endclass

module tb_ring_server_allocator_core;
  import rsa_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS    = 185;
  localparam int NUM_PHASES     = 10;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic [TIME_W-1:0]    arrival_time;
  logic [TIME_W-1:0]    service_time;
  logic                 out_valid;
  logic                 out_ready;
  logic                 granted;
  logic [OUT_IDX_W-1:0] server_index;
  logic [COUNT_W-1:0]   served_count;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_W-1:0]     cfg_data;

  alloc_scoreboard sb = new();
  int              idle_count;
  int              ready_hold;
  logic            quiet;

  ring_server_allocator_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .arrival_time (arrival_time),
    .service_time (service_time),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .granted      (granted),
    .server_index (server_index),
    .served_count (served_count),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Mostly short pauses, now and then a long one
  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold--;
      out_ready <= 1'b0;
    end else if (quiet || $urandom_range(0, 3) != 0) begin
      out_ready <= 1'b1;
    end else begin
      ready_hold = pause_len();
      out_ready <= 1'b0;
    end
  end

  // Check results before noting requests: no result belongs to a request
  // accepted at the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_grant(granted, server_index, served_count);
      if (cfg_valid && cfg_ready) sb.set_servers(cfg_data);
      if (in_valid && in_ready) sb.note_request(arrival_time, service_time);
      if ((out_valid && out_ready) || (cfg_valid && cfg_ready) || (in_valid && in_ready))
        idle_count = 0;
      else
        idle_count++;
      if (idle_count >= WATCHDOG_LIMIT) begin
        $display("tb_ring_server_allocator_core NOT OK");
        $finish;
      end
    end
  end

  task automatic send_request(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] s);
    int gap;
    gap = quiet ? 0 : pause_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    arrival_time <= a;
    service_time <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Write the server count once every queued grant has been taken
  task automatic write_servers(input logic [CFG_W-1:0] v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_grants.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [CFG_W-1:0]  cfg_plan [NUM_PHASES];
    logic [CFG_W-1:0]  cfg_v;
    logic [TIME_W-1:0] now_at;
    logic [TIME_W-1:0] svc;
    int                eff;
    int                r;
    cfg_plan     = '{7'd1, 7'd64, 7'd2, 7'd127, 7'd0, 7'd5, 7'd65, 7'd17, 7'd63, 7'd3};
    rst          = 1'b1;
    in_valid     = 1'b0;
    arrival_time = '0;
    service_time = '0;
    out_ready    = 1'b0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    quiet        = 1'b0;
    idle_count   = 0;
    ready_hold   = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Full ring after reset: extremes, release saturation, arrival going back
    send_request(32'h0000_0000, 32'h0000_0000);
    send_request(32'h0000_0000, 32'hFFFF_FFFF);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(32'hFFFF_FFFF, 32'h0000_0000);
    send_request(32'h0000_0010, 32'h0000_0005);
    send_request(32'h0000_0008, 32'h0000_0001);
    // Shrink the ring past the sequence number, then force a reject
    write_servers(7'd3);
    send_request(32'd20, 32'd4);
    send_request(32'd21, 32'd1);
    send_request(32'd24, 32'd0);
    send_request(32'd25, 32'h8000_0000);
    // Zero servers acts as one
    write_servers(7'd0);
    send_request(32'd30, 32'd5);
    send_request(32'h8000_0019, 32'd0);
    send_request(32'h8000_0019, 32'd3);
    // Counts above the ring size clamp to the full ring
    write_servers(7'd127);
    send_request(32'hFFFF_FFFE, 32'd1);
    send_request(32'h5555_5555, 32'hAAAA_AAAA);
    write_servers(7'd65);
    send_request(32'hAAAA_AAAA, 32'h5555_5555);
    send_request(32'h1234_5678, 32'hFEDC_BA98);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      quiet = (ph % 4 == 3);
      cfg_v = (ph >= 8) ? CFG_W'($urandom_range(0, 127)) : cfg_plan[ph];
      write_servers(cfg_v);
      eff = (cfg_v == 0) ? 1 : (cfg_v > MAX_SERVERS_DEF) ? MAX_SERVERS_DEF : int'(cfg_v);
      now_at = $urandom();
      repeat (PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 90) begin
          // Load near the ring's capacity so grants and rejects mix
          now_at = now_at + $urandom_range(0, 4);
          svc    = $urandom_range(0, 3 * eff + 4);
        end else if (r < 93) begin
          now_at = now_at + $urandom_range(0, 4);
          svc    = $urandom();
        end else if (r < 97) begin
          now_at = $urandom();
          svc    = $urandom_range(0, 3 * eff + 4);
        end else begin
          now_at = now_at - $urandom_range(1, 64);
          svc    = $urandom_range(0, 8);
        end
        send_request(now_at, svc);
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_grants.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.expected_grants.size() != 0)
      sb.report($sformatf("%0d grants never arrived", sb.expected_grants.size()));
    if (sb.failures == 0)
      $display("tb_ring_server_allocator_core OK");
    else
      $display("tb_ring_server_allocator_core NOT OK");
    $finish;
  end

endmodule
